// ----- sv/fpr_pkg.sv -----
package fpr_pkg;

    // Fixed widths of the port fields
    localparam int PAGE_W  = 20;
    localparam int CAP_W   = 5;
    localparam int COUNT_W = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } ctl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic start;   // latch page, set up the scan window
        logic scan;    // walk the resident window, one frame per cycle
        logic commit;  // apply the replacement and load the result
    } fpr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;  // every resident frame compared
        logic out_free;   // result register can take a new value
    } fpr_sts_t;

endpackage

// ----- sv/fpr_ctrl.sv -----
module fpr_ctrl
    import fpr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     access_valid,
    output logic     access_stall,
    input  fpr_sts_t sts,
    output fpr_cmd_t cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (access_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        access_stall = 1'b1;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                access_stall = 1'b0;
                cmd.start    = access_valid;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_DONE:
            begin
                cmd.commit = sts.out_free;
            end
            default:
            begin
                access_stall = 1'b1;
            end
        endcase
    end

endmodule

// ----- sv/fpr_dp.sv -----
module fpr_dp
    import fpr_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int PAGE_BITS = 20
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               capacity_we,
    input  logic [CAP_W-1:0]   capacity,
    input  logic [PAGE_W-1:0]  page_number,
    output logic               result_valid,
    input  logic               result_stall,
    output logic               fault,
    output logic [COUNT_W-1:0] fault_count,
    input  fpr_cmd_t           cmd,
    output fpr_sts_t           sts
);

    localparam int KEY_BITS  = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
    localparam int SLOT_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int CW        = (CNT_BITS > CAP_W) ? CNT_BITS : CAP_W;
    localparam int RST_CAP   = (DEPTH < 16) ? DEPTH : 16;

    logic [KEY_BITS-1:0]  frame [DEPTH];

    logic [CNT_BITS-1:0]  cap_reg;
    logic [SLOT_BITS-1:0] oldest_reg;
    logic [CNT_BITS-1:0]  occ_reg;
    logic [COUNT_W-1:0]   total_reg;
    logic [KEY_BITS-1:0]  page_reg;
    logic [SLOT_BITS-1:0] ptr_reg;
    logic [CNT_BITS-1:0]  remain_reg;
    logic                 pend_reg;
    logic                 hit_reg;
    logic [KEY_BITS-1:0]  rd_data_reg;
    logic                 out_valid_reg;
    logic                 out_fault_reg;
    logic [COUNT_W-1:0]   out_count_reg;

    logic [CW-1:0]        cap_w;
    logic [CNT_BITS-1:0]  cap_clamped;
    logic                 issue;
    logic [SLOT_BITS-1:0] ptr_inc;
    logic [SLOT_BITS-1:0] oldest_inc;
    logic                 miss;
    logic [COUNT_W-1:0]   total_inc;

    // Clamp the written capacity into 1..DEPTH
    always_comb
    begin
        cap_w = CW'(capacity);
        if (cap_w == '0)
        begin
            cap_clamped = CNT_BITS'(1);
        end
        else if (cap_w > CW'(DEPTH))
        begin
            cap_clamped = CNT_BITS'(DEPTH);
        end
        else
        begin
            cap_clamped = cap_w[CNT_BITS-1:0];
        end
    end

    assign issue      = cmd.scan && (remain_reg != '0);
    assign ptr_inc    = (CNT_BITS'(ptr_reg) == cap_reg - CNT_BITS'(1))
                        ? '0 : ptr_reg + SLOT_BITS'(1);
    assign oldest_inc = (CNT_BITS'(oldest_reg) == cap_reg - CNT_BITS'(1))
                        ? '0 : oldest_reg + SLOT_BITS'(1);
    assign miss       = !hit_reg;
    assign total_inc  = (total_reg == '1) ? total_reg : total_reg + COUNT_W'(1);

    assign sts.scan_done = (remain_reg == '0) && !pend_reg;
    assign sts.out_free  = !out_valid_reg || !result_stall;

    // Frame store: one read a cycle while scanning, one write on a miss.
    // The scan walks the resident window from the oldest frame, so after
    // it ends the pointer sits on the frame a miss must fill.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg <= frame[ptr_reg];
        end
        if (cmd.commit && miss)
        begin
            frame[ptr_reg] <= page_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            page_reg <= page_number[KEY_BITS-1:0];
        end
        if (cmd.commit)
        begin
            out_fault_reg <= miss;
            out_count_reg <= miss ? total_inc : total_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CNT_BITS'(RST_CAP);
            oldest_reg    <= '0;
            occ_reg       <= '0;
            total_reg     <= '0;
            ptr_reg       <= '0;
            remain_reg    <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= issue;
            if (capacity_we)
            begin
                cap_reg    <= cap_clamped;
                oldest_reg <= '0;
                occ_reg    <= '0;
            end
            if (cmd.start)
            begin
                ptr_reg    <= oldest_reg;
                remain_reg <= occ_reg;
                hit_reg    <= 1'b0;
            end
            if (issue)
            begin
                ptr_reg    <= ptr_inc;
                remain_reg <= remain_reg - CNT_BITS'(1);
            end
            if (pend_reg && (rd_data_reg == page_reg))
            begin
                hit_reg <= 1'b1;
            end
            if (cmd.commit && miss)
            begin
                total_reg <= total_inc;
                if (occ_reg < cap_reg)
                begin
                    occ_reg <= occ_reg + CNT_BITS'(1);
                end
                else
                begin
                    oldest_reg <= oldest_inc;
                end
            end
            // Hold the result until the transfer completes
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign fault        = out_fault_reg;
    assign fault_count  = out_count_reg;

endmodule

// ----- sv/fifo_page_replacement_top.sv -----
// Fully associative page store with first-in first-out replacement. Each
// accepted page number is compared with the resident frames one frame per
// cycle, read from a single-port frame memory starting at the oldest frame.
// With occupancy resident frames an access steps through accept, a read of each
// resident frame, the compare of the last memory read, the close of the scan,
// and commit; an empty store closes the scan at once and goes on to commit.
// A miss writes the page into the next free frame or over the oldest one and
// bumps the saturating fault count; a hit leaves the store alone. Writing
// capacity (0 acts as 1, values above DEPTH act as DEPTH) empties the store
// but keeps the fault count.
// A result waiting on result_stall holds the block before its next commit.
module fifo_page_replacement_top
    import fpr_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int PAGE_BITS = 20
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               capacity_we,
    input  logic [CAP_W-1:0]   capacity,
    input  logic               access_valid,
    output logic               access_stall,
    input  logic [PAGE_W-1:0]  page_number,
    output logic               result_valid,
    input  logic               result_stall,
    output logic               fault,
    output logic [COUNT_W-1:0] fault_count
);

    fpr_cmd_t cmd;
    fpr_sts_t sts;

    fpr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .access_valid (access_valid),
        .access_stall (access_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    fpr_dp #(
        .DEPTH     (DEPTH),
        .PAGE_BITS (PAGE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .capacity_we  (capacity_we),
        .capacity     (capacity),
        .page_number  (page_number),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .fault        (fault),
        .fault_count  (fault_count),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

// ----- tb/tb_fifo_page_replacement_top.sv -----
`timescale 1ns / 100ps

module tb_fifo_page_replacement_top;
    import fpr_pkg::*;

    localparam int FRAMES       = 16;
    localparam int ITEMS_PER_RUN = 52;
    localparam int HOLD_CYCLES  = 300;
    localparam int NUM_PHASES   = 12;

    typedef struct packed {
        logic               fault;
        logic [COUNT_W-1:0] count;
    } outcome_t;

    class page_fifo_scoreboard;
        logic [PAGE_W-1:0]  frame_page [FRAMES];
        bit                 frame_valid [FRAMES];
        int unsigned        head;
        int unsigned        fill;
        logic [CAP_W-1:0]   cap_reg;
        logic [COUNT_W-1:0] faults;
        outcome_t           expected_q [$];
        int                 errors;
        int                 hits;
        int                 misses;
        int                 cap_writes;

        function new();
            cap_reg    = CAP_W'(FRAMES);
            faults     = '0;
            errors     = 0;
            hits       = 0;
            misses     = 0;
            cap_writes = 0;
            empty_store();
        endfunction

        function void empty_store();
            for (int i = 0; i < FRAMES; i++)
            begin
                frame_page[i]  = '0;
                frame_valid[i] = 1'b0;
            end
            head = 0;
            fill = 0;
        endfunction

        // 0 behaves as one frame, anything past the store size as the full store
        function int unsigned frames_in_use();
            if (cap_reg == 0)
                return 1;
            if (cap_reg > FRAMES)
                return FRAMES;
            return 32'(cap_reg);
        endfunction

        function void set_capacity(logic [CAP_W-1:0] val);
            cap_reg = val;
            cap_writes++;
            empty_store();
        endfunction

        function void note_access(logic [PAGE_W-1:0] pg);
            int unsigned cap;
            int unsigned slot;
            bit          hit;
            outcome_t    exp;
            cap = frames_in_use();
            hit = 1'b0;
            for (int i = 0; i < cap; i++)
            begin
                if (frame_valid[i] && frame_page[i] == pg)
                    hit = 1'b1;
            end
            if (!hit)
            begin
                if (fill < cap)
                begin
                    slot = head + fill;
                    if (slot >= cap)
                        slot -= cap;
                    fill++;
                end
                else
                begin
                    // evict the oldest frame and advance the head
                    slot = head;
                    head = (head + 1 >= cap) ? 0 : head + 1;
                end
                frame_page[slot]  = pg;
                frame_valid[slot] = 1'b1;
                if (faults != '1)
                    faults++;
                misses++;
            end
            else
                hits++;
            exp.fault = !hit;
            exp.count = faults;
            expected_q.push_back(exp);
        endfunction

        function void check_result(logic f, logic [COUNT_W-1:0] cnt);
            outcome_t exp;
            if (expected_q.size() == 0)
            begin
                $error("result with no access pending: fault=%0d fault_count=%0d", f, cnt);
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            if (f !== exp.fault)
            begin
                $error("fault: expected %0d, got %0d", exp.fault, f);
                errors++;
            end
            if (cnt !== exp.count)
            begin
                $error("fault_count: expected %0d, got %0d", exp.count, cnt);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               capacity_we   = 1'b0;
    logic [CAP_W-1:0]   capacity      = '0;
    logic               access_valid  = 1'b0;
    logic               access_stall;
    logic [PAGE_W-1:0]  page_number   = '0;
    logic               result_valid;
    logic               result_stall  = 1'b0;
    logic               fault;
    logic [COUNT_W-1:0] fault_count;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_go       = 1'b0;
    logic        hold_active   = 1'b0;

    page_fifo_scoreboard tracker = new();

    fifo_page_replacement_top #(
        .DEPTH     (FRAMES),
        .PAGE_BITS (PAGE_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .capacity_we  (capacity_we),
        .capacity     (capacity),
        .access_valid (access_valid),
        .access_stall (access_stall),
        .page_number  (page_number),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .fault        (fault),
        .fault_count  (fault_count)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                tracker.check_result(fault, fault_count);
            result_stall <= hold_active || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // long receiver hold-off so the block backs up into its input;
    // start it at the capacity write that opens the phase so pages keep coming
    initial
    begin
        wait (hold_go);
        wait (capacity_we);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("fifo_page_replacement_top: mismatch");
        $finish;
    end

    task automatic offer_page(input logic [PAGE_W-1:0] pg);
        if ($urandom_range(99) < send_idle_pct)
        begin
            access_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        access_valid <= 1'b1;
        page_number  <= pg;
        @(posedge clk);
        while (access_stall)
            @(posedge clk);
        tracker.note_access(pg);
    endtask

    task automatic drain_results();
        access_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] val);
        drain_results();
        capacity_we <= 1'b1;
        capacity    <= val;
        @(posedge clk);
        capacity_we <= 1'b0;
        tracker.set_capacity(val);
    endtask

    task automatic run_random_phase(input logic [CAP_W-1:0] cap_val);
        logic [PAGE_W-1:0] base;
        logic [PAGE_W-1:0] pg;
        int unsigned       span;
        write_capacity(cap_val);
        base = PAGE_W'($urandom);
        span = tracker.frames_in_use() + 3;
        for (int n = 0; n < ITEMS_PER_RUN; n++)
        begin
            // mostly a small working set around the frame count, some stray pages
            if ($urandom_range(99) < 85)
                pg = base + PAGE_W'($urandom_range(span - 1));
            else
                pg = PAGE_W'($urandom);
            offer_page(pg);
        end
    endtask

    initial
    begin
        logic [CAP_W-1:0] caps [NUM_PHASES];
        caps = '{5'd2, 5'd16, 5'd1, 5'd5, 5'd31, 5'd3,
                 5'd8, 5'd0, 5'd12, 5'd4, 5'd20, 5'd16};

        send_idle_pct = 32;
        recv_idle_pct = 81;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // store starts empty at full capacity
        offer_page(20'h00000);
        offer_page(20'hFFFFF);
        offer_page(20'h00000);
        offer_page(20'hFFFFF);
        offer_page(20'hAAAAA);
        offer_page(20'h55555);

        // a capacity write empties the store, single frame
        write_capacity(5'd1);
        offer_page(20'h00000);
        offer_page(20'h00000);
        offer_page(20'h00001);
        offer_page(20'h00000);

        // zero acts as a single frame
        write_capacity(5'd0);
        offer_page(20'h00007);
        offer_page(20'h00007);
        offer_page(20'h00008);
        offer_page(20'h00007);

        // two frames: evict the oldest, then re-fault on it
        write_capacity(5'd2);
        offer_page(20'h00003);
        offer_page(20'h00004);
        offer_page(20'h00003);
        offer_page(20'h00005);
        offer_page(20'h00003);
        offer_page(20'h00004);

        // above the store size acts as the full store
        write_capacity(5'd31);
        offer_page(20'h00009);
        offer_page(20'h00009);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == 4)
            begin
                send_idle_pct = 81;
                recv_idle_pct = 32;
            end
            else if (p == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 9)
                hold_go = 1'b1;
            run_random_phase(caps[p]);
        end

        drain_results();
        repeat (20) @(posedge clk);

        $display("covered %0d accesses: %0d hits, %0d faults, %0d capacity writes",
                 tracker.hits + tracker.misses, tracker.hits, tracker.misses,
                 tracker.cap_writes);
        $display("capacities 0..31 incl. out-of-range values, with both sides stalling");
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("fifo_page_replacement_top: match");
        else
            $display("fifo_page_replacement_top: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/fpr_pkg.sv
sv/fpr_ctrl.sv
sv/fpr_dp.sv
sv/fifo_page_replacement_top.sv
tb/tb_fifo_page_replacement_top.sv
